>>> design/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// shared constants for the first repeating position unit
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

    // fixed field widths of the stream interface
    localparam int IN_VALUE_BITS = 10;
    localparam int POS_BITS      = 11;
    localparam int S_TDATA_BITS  = 16;
    localparam int M_TDATA_BITS  = 16;

    // occurrence counters saturate at three
    localparam int                  COUNT_BITS = 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 2'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = 2'd1;

    // parameter defaults
    localparam int DEF_MAX_ITEMS  = 1024;
    localparam int DEF_VALUE_BITS = 10;

endpackage

`default_nettype wire

>>> design/frp_value_mem.sv
// ----------------------------------------------------------------------------
// frp_value_mem
// value store: holds the set's values in arrival order, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module frp_value_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/frp_count_mem.sv
// ----------------------------------------------------------------------------
// frp_count_mem
// occurrence count table with saturating read-modify-write and clearing
// ----------------------------------------------------------------------------
`default_nettype none

module frp_count_mem #(
    parameter int VALUE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [VALUE_BITS-1:0]             i_addr,
    input  wire logic                              i_inc,
    input  wire logic                              i_clr,
    output logic      [frp_pkg::COUNT_BITS-1:0]    o_rd_count
);

    import frp_pkg::*;

    localparam int DEPTH = 1 << VALUE_BITS;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd;

    // update stage: read issued last cycle, write back this cycle
    logic                  r_s1_v;
    logic [VALUE_BITS-1:0] r_s1_addr;

    // write done at the same edge as the pending read
    logic                  r_fwd_v;
    logic [VALUE_BITS-1:0] r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_cnt;

    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] n_cnt;

    always_comb begin
        old_cnt = (r_fwd_v && (r_fwd_addr == r_s1_addr)) ? r_fwd_cnt : r_rd;
        n_cnt   = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_addr] <= '0;
        end else if (r_s1_v) begin
            r_mem[r_s1_addr] <= n_cnt;
        end
        r_rd       <= r_mem[i_addr];
        r_s1_addr  <= i_addr;
        r_fwd_addr <= r_s1_addr;
        r_fwd_cnt  <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            r_s1_v  <= i_inc;
            r_fwd_v <= r_s1_v && !i_clr;
        end
    end

    assign o_rd_count = r_rd;

endmodule

`default_nettype wire

>>> design/first_repeating_position_unit.sv
// ----------------------------------------------------------------------------
// first_repeating_position_unit
// finds the 1-based position of the first value in a set that repeats
// ----------------------------------------------------------------------------
// Values stream in on the slave side, one transaction per cycle, and each is
// stored in arrival order while its occurrence count (saturating at three) is
// bumped in a count table. The transaction with s_tlast high is part of the
// set and closes it; values past MAX_ITEMS are dropped but a tlast on them
// still closes the set. The unit then scans the stored values in order and
// sends one transaction on the master side: the position of the first value
// that occurs more than once, or zero when nothing repeats. The scan makes
// one value-store read, then one count-table read per position, pipelined;
// the result then moves to the output register once it is free; then the
// count table is cleared, one entry per cycle, over all 2**VALUE_BITS
// entries. The same clearing pass runs after reset. s_tready is low during
// scan, hand-over and clearing; a finished result may wait in the output
// register while the next set loads.
// ----------------------------------------------------------------------------
`default_nettype none

module first_repeating_position_unit #(
    parameter int MAX_ITEMS  = frp_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = frp_pkg::DEF_VALUE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [frp_pkg::S_TDATA_BITS-1:0] s_tdata,  // [9:0] value, rest zero
    input  wire logic                             s_tlast,  // last element of the set
    // master side
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [frp_pkg::M_TDATA_BITS-1:0] m_tdata   // [10:0] position, rest zero
);

    import frp_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1; // value store address
    localparam int IW = $clog2(MAX_ITEMS + 1);                   // item count
    localparam int PW = (IW + 1 > POS_BITS) ? IW + 1 : POS_BITS; // position before masking
    localparam logic [IW-1:0] MAX_COUNT = IW'(MAX_ITEMS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_LOAD,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [IW-1:0]         r_count;     // stored elements in the current set
    logic [VALUE_BITS-1:0] r_clr;       // clearing pass pointer
    logic [IW-1:0]         r_scan_idx;  // next position to fetch
    logic                  r_p1_v;      // value-store read in flight
    logic [IW-1:0]         r_p1_idx;
    logic                  r_p2_v;      // count-table read in flight
    logic [IW-1:0]         r_p2_idx;
    logic [POS_BITS-1:0]   r_res;
    logic                  r_out_valid;
    logic [POS_BITS-1:0]   r_out_pos;

    logic [VALUE_BITS-1:0] in_value;
    logic                  in_take;
    logic                  in_store;
    logic [VALUE_BITS-1:0] stored_rd;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [VALUE_BITS-1:0] cnt_addr;
    logic                  found;
    logic                  issue;
    logic                  scan_empty;
    logic [PW-1:0]         pos_wide;
    logic                  out_load;

    // only the low VALUE_BITS of the value take part
    assign in_value = VALUE_BITS'(s_tdata[IN_VALUE_BITS-1:0]);
    assign s_tready = (r_state == S_LOAD);
    assign in_take  = s_tvalid && s_tready;
    assign in_store = in_take && (r_count < MAX_COUNT);

    // scan pipeline controls
    assign found      = (r_state == S_SCAN) && r_p2_v && (cnt_rd > COUNT_ONE);
    assign issue      = !found && (r_scan_idx < r_count);
    assign scan_empty = !issue && !r_p1_v && !r_p2_v;
    assign pos_wide   = PW'(r_p2_idx) + PW'(1);

    // finished result moves into a free or draining output register
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || m_tready);

    // count table address: clearing pointer, incoming value, or fetched value
    always_comb begin
        unique case (r_state)
            S_CLEAR: cnt_addr = r_clr;
            S_LOAD:  cnt_addr = in_value;
            default: cnt_addr = stored_rd;
        endcase
    end

    frp_value_mem #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_BITS)
    ) u_values (
        .i_clk     (i_clk),
        .i_wr_en   (in_store),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (in_value),
        .i_rd_addr (r_scan_idx[AW-1:0]),
        .o_rd_data (stored_rd)
    );

    frp_count_mem #(
        .VALUE_BITS (VALUE_BITS)
    ) u_counts (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (cnt_addr),
        .i_inc      (in_store),
        .i_clr      (r_state == S_CLEAR),
        .o_rd_count (cnt_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_count     <= '0;
            r_clr       <= '0;
            r_scan_idx  <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // master side drains independently of the state
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {VALUE_BITS{1'b1}}) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (in_store) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (in_take && s_tlast) begin
                        r_state    <= S_SCAN;
                        r_scan_idx <= '0;
                        r_p1_v     <= 1'b0;
                        r_p2_v     <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_p1_v   <= issue;
                    r_p1_idx <= r_scan_idx;
                    r_p2_v   <= r_p1_v && !found;
                    r_p2_idx <= r_p1_idx;
                    if (issue) begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                    if (found) begin
                        r_res   <= pos_wide[POS_BITS-1:0];
                        r_state <= S_FINISH;
                    end else if (scan_empty) begin
                        r_res   <= '0;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_out_pos   <= r_res;
                        r_count     <= '0;
                        r_clr       <= '0;
                        r_p1_v      <= 1'b0;
                        r_p2_v      <= 1'b0;
                        r_state     <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_TDATA_BITS'(r_out_pos);

endmodule

`default_nettype wire

>>> tb/first_repeating_position_unit_tb.sv
// ----------------------------------------------------------------------------
// first_repeating_position_unit_tb
// self-checking bench for the first repeating position unit
// ----------------------------------------------------------------------------
// A queue of pending elements feeds a clocked stream driver. Every accepted
// transaction goes through a bench-side copy of the count table and value
// store. A set-closing transaction yields the expected position. A clocked
// monitor checks each result transaction against the oldest expected
// position. Stimulus covers these cases:
//   - short directed sets: extremes, saturation and a cleared table
//   - one set that overflows the value store
//   - many small random sets with dense or sparse values
// Both sides idle at random. The receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module first_repeating_position_unit_tb;

    import frp_pkg::*;

    localparam int MAX_ELEMS   = DEF_MAX_ITEMS;
    localparam int VALUE_SPAN  = 1 << DEF_VALUE_BITS;
    localparam int VMAX        = VALUE_SPAN - 1;
    localparam int TAIL_CYCLES = 1200;     // scan plus clearing pass, with margin
    localparam int LONG_HOLD   = 4000;     // long receiver hold-off, in cycles
    localparam int CYCLE_LIMIT = 1000000;

    // one pending element of a data set
    typedef struct {
        logic [IN_VALUE_BITS-1:0] value;
        logic                     last;
        int unsigned              gap;     // idle cycles before it is offered
        bit                       drain;   // wait for all results before offering
    } t_elem;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;  // [9:0] value, rest zero
    logic                    s_tlast  = 1'b0; // last element of the set
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;        // [10:0] position, rest zero

    // stimulus and expected results
    t_elem              pending_q[$];
    logic [POS_BITS-1:0] first_pos_q[$];
    int unsigned        n_predicted = 0;     // nonblocking, read across blocks
    int unsigned        n_checked   = 0;     // nonblocking, read across blocks
    int unsigned        n_errors    = 0;
    int unsigned        cycle_cnt   = 0;
    bit                 tx_quiet    = 1'b0;

    // bench-side copy of the unit's state
    logic [COUNT_BITS-1:0]    occ_cnt   [0:VALUE_SPAN-1];
    logic [IN_VALUE_BITS-1:0] kept_vals [0:MAX_ELEMS-1];
    int unsigned              set_len = 0;

    first_repeating_position_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // store and count one accepted element; a closing element yields a position
    task automatic tally_element(input logic [IN_VALUE_BITS-1:0] v, input logic closes);
        int unsigned pos;
        pos = 0;
        // elements past the store depth are dropped, but a last flag still counts
        if (set_len < MAX_ELEMS) begin
            kept_vals[set_len] = v;
            set_len++;
            if (occ_cnt[v] != COUNT_MAX)
                occ_cnt[v] = occ_cnt[v] + COUNT_ONE;
        end
        if (closes) begin
            for (int k = 0; k < set_len; k++) begin
                if (pos == 0 && occ_cnt[kept_vals[k]] > COUNT_ONE)
                    pos = k + 1;
            end
            first_pos_q.insert(first_pos_q.size(), pos[POS_BITS-1:0]);
            for (int k = 0; k < VALUE_SPAN; k++)
                occ_cnt[k] = '0;
            set_len = 0;
        end
    endtask

    task automatic add_elem(input int unsigned v, input bit closes, input bit drain);
        t_elem e;
        e.value = v[IN_VALUE_BITS-1:0];
        e.last  = closes;
        e.gap   = tx_quiet ? 0 : $urandom_range(0, 14);
        e.drain = drain;
        pending_q.insert(pending_q.size(), e);
    endtask

    // ------------------------------------------------------------------
    // driver: offers the head of the pending queue after its gap, holds it
    // until the transaction completes, and feeds accepted elements to the
    // predictor
    // ------------------------------------------------------------------
    int unsigned gap_left  = 0;
    bit          gap_armed = 1'b0;

    always @(posedge i_clk) begin
        bit present;
        bit closed;
        present = 1'b0;
        closed  = 1'b0;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                tally_element(pending_q[0].value, pending_q[0].last);
                closed = pending_q[0].last;
                void'(pending_q.pop_front());
                gap_armed = 1'b0;
            end else if (s_tvalid) begin
                present = 1'b1;                  // keep offering the same element
            end
            if (!present && pending_q.size() > 0) begin
                if (!gap_armed) begin
                    gap_left  = pending_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!pending_q[0].drain || (!closed && n_predicted == n_checked))
                    present = 1'b1;
            end
        end
        // one nonblocking write per signal and step
        s_tvalid <= present;
        if (present) begin
            s_tdata <= {{(S_TDATA_BITS-IN_VALUE_BITS){1'b0}}, pending_q[0].value};
            s_tlast <= pending_q[0].last;
        end
        if (closed)
            n_predicted <= n_predicted + 1;
    end

    // ------------------------------------------------------------------
    // receiver: random stall per result, quiet stretches, and one long
    // hold-off so the output register fills and the input side stalls
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    bit          long_done  = 1'b0;
    bit          rx_quiet   = 1'b0;

    always @(posedge i_clk) begin
        bit rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 3) == 0)
                    rx_quiet = !rx_quiet;
                stall_left = rx_quiet ? 0 : $urandom_range(0, 14);
            end
            if (!long_done && n_checked == 4) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else
                rdy = 1'b1;
        end
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // monitor: every result transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [POS_BITS-1:0] want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (n_checked == n_predicted) begin
                $error("unexpected result transaction: position %0d", m_tdata[POS_BITS-1:0]);
                n_errors++;
            end else begin
                want = first_pos_q.pop_front();
                if (m_tdata[POS_BITS-1:0] !== want) begin
                    $error("position mismatch: expected %0d, actual %0d",
                           want, m_tdata[POS_BITS-1:0]);
                    n_errors++;
                end
                n_checked <= n_checked + 1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned              len;
        int unsigned              pool;
        int unsigned              base;
        int unsigned              n_small;
        int unsigned              j;
        bit                       narrow;
        bit                       drain;
        bit                       big_done;
        logic [IN_VALUE_BITS-1:0] perm [0:VALUE_SPAN-1];
        logic [IN_VALUE_BITS-1:0] tmp;

        for (int k = 0; k < VALUE_SPAN; k++)
            occ_cnt[k] = '0;

        // single-element set, nothing can repeat
        add_elem(0, 1, 0);
        // top value twice
        add_elem(VMAX, 0, 0);
        add_elem(VMAX, 1, 0);
        // repeat found after a unique value
        add_elem(5, 0, 0);
        add_elem(7, 0, 0);
        add_elem(9, 0, 0);
        add_elem(7, 1, 0);
        // counter saturates at three
        add_elem(3, 0, 0);
        add_elem(3, 0, 0);
        add_elem(3, 0, 0);
        add_elem(3, 0, 0);
        add_elem(3, 1, 0);
        // same value alone must see a cleared table; sender waits for all results
        add_elem(3, 1, 1);
        // extremes mixed, repeat of zero
        add_elem(VMAX, 0, 0);
        add_elem(0, 0, 0);
        add_elem(512, 0, 0);
        add_elem(0, 1, 0);

        // random sets, mostly short, often with dense value pools to make repeats
        n_small  = 0;
        big_done = 1'b0;
        while (n_small < 720) begin
            if (!big_done && n_small >= 300) begin
                // overflow set: unique values, a repeat at the last stored
                // position, then dropped elements that would repeat earlier
                big_done = 1'b1;
                for (int k = 0; k < VALUE_SPAN; k++)
                    perm[k] = k[IN_VALUE_BITS-1:0];
                for (int k = VALUE_SPAN - 1; k > 0; k--) begin
                    j       = $urandom_range(0, k);
                    tmp     = perm[k];
                    perm[k] = perm[j];
                    perm[j] = tmp;
                end
                for (int k = 0; k < MAX_ELEMS - 2; k++)
                    add_elem(perm[k], 0, k == 0);
                add_elem(perm[VALUE_SPAN-1], 0, 0);
                add_elem(perm[VALUE_SPAN-1], 0, 0);
                add_elem(perm[0], 0, 0);
                add_elem(perm[5], 1, 0);
            end
            if ($urandom_range(0, 3) == 0)
                tx_quiet = !tx_quiet;
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 100)
                                                 : $urandom_range(1, 24);
            narrow = ($urandom_range(0, 2) != 0);
            pool   = $urandom_range(0, 2 * len);
            base   = $urandom_range(0, VMAX - pool);
            drain  = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < len; k++)
                add_elem(narrow ? base + $urandom_range(0, pool) : $urandom_range(0, VMAX),
                         k == len - 1, drain && k == 0);
            n_small += len;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all elements accepted and every expected position seen
        do
            @(negedge i_clk);
        while (pending_q.size() != 0 || s_tvalid || n_predicted != n_checked);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

>>> first_repeating_position_unit.f
design/frp_pkg.sv
design/frp_value_mem.sv
design/frp_count_mem.sv
design/first_repeating_position_unit.sv
tb/first_repeating_position_unit_tb.sv
